>>> rtl/fjop_pkg.sv
// shared types and codes for the flat json object parser
package fjop_pkg;

	typedef enum logic [3:0] {
		PH_OPEN      = 4'd0,
		PH_FIRST     = 4'd1,
		PH_KEY       = 4'd2,
		PH_KEY_ESC   = 4'd3,
		PH_COLON     = 4'd4,
		PH_VAL_OPEN  = 4'd5,
		PH_VAL       = 4'd6,
		PH_VAL_ESC   = 4'd7,
		PH_AFTER_VAL = 4'd8,
		PH_NEXT_KEY  = 4'd9,
		PH_TRAIL     = 4'd10
	} phase_t;

	localparam logic [2:0] KIND_NONE    = 3'd0;
	localparam logic [2:0] KIND_KEY     = 3'd1;
	localparam logic [2:0] KIND_VAL     = 3'd2;
	localparam logic [2:0] KIND_KEY_END = 3'd3;
	localparam logic [2:0] KIND_VAL_END = 3'd4;

	localparam logic [1:0] VERDICT_UNDECIDED = 2'd0;
	localparam logic [1:0] VERDICT_ACCEPTED  = 2'd1;
	localparam logic [1:0] VERDICT_REJECTED  = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       final_byte;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] kind;
		logic [1:0] verdict;
		logic       message_end;
	} out_beat_t;

	typedef struct packed {
		phase_t phase;
		logic   rejected;
		logic   empty_closed;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{phase: PH_OPEN, rejected: 1'b0,
		empty_closed: 1'b0};

endpackage

>>> rtl/flat_json_object_parser.sv
// top level: streaming checker and decoder for flat json string objects
// Takes one message byte per beat and returns exactly one result beat per input
// beat, in order. A beat is registered on input, goes through the combinational
// parser logic and lands in the output register, where it waits for out_ready;
// with out_ready held high a new byte is accepted every cycle. That figure is
// set by the parser state register, which is updated once per byte in the
// cycle the byte moves to the output register.
// The verdict in a beat with message_end set is final, and the parser starts
// over with the next byte.
module flat_json_object_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fjop_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output fjop_pkg::out_beat_t out_data
);

	logic                   valid_s1;
	fjop_pkg::in_beat_t     data_s1;
	fjop_pkg::parse_state_t state_q;
	fjop_pkg::parse_state_t state_nxt;
	fjop_pkg::out_beat_t    result;
	logic                   advance;

	// stage one moves on whenever the output register is empty or being drained
	assign advance  = !out_valid || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	fjop_step u_step (
		.cur    (state_q),
		.item   (data_s1),
		.nxt    (state_nxt),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fjop_pkg::STATE_RESET;
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
			if (valid_s1) state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data <= result;
		end
	end

	// apart from a message's last beat, emitted characters only come from a live, undecided message
	a_kind_undecided: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.message_end && out_data.kind != fjop_pkg::KIND_NONE
		|-> out_data.verdict == fjop_pkg::VERDICT_UNDECIDED)
		else $error("character emitted with a decided verdict");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != fjop_pkg::KIND_KEY
		&& out_data.kind != fjop_pkg::KIND_VAL |-> out_data.out_byte == 8'h00)
		else $error("nonzero byte on a beat that carries no character");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && data_s1.final_byte
		|=> state_q == fjop_pkg::STATE_RESET)
		else $error("parser did not restart after the last byte");

	a_sticky_reject: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.rejected && !(advance && valid_s1 && data_s1.final_byte)
		|=> state_q.rejected)
		else $error("rejection dropped before the last byte");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && valid_s1) |=> $stable(state_q))
		else $error("parser state moved without a byte");

endmodule

>>> rtl/fjop_step.sv
// one-byte parser transition: next phase, decoded byte, kind and verdict
module fjop_step (
	input  fjop_pkg::parse_state_t cur,
	input  fjop_pkg::in_beat_t     item,
	output fjop_pkg::parse_state_t nxt,
	output fjop_pkg::out_beat_t    result
);

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
	endfunction

	logic [7:0] c;
	logic       esc_ok;
	logic [7:0] esc_dec;
	logic       bad;
	logic [7:0] ob;
	logic [2:0] kind;
	logic [1:0] verdict;
	fjop_pkg::parse_state_t st;

	assign c = item.in_byte;

	// escape letters and what they stand for
	always_comb begin
		esc_ok  = 1'b1;
		esc_dec = 8'h00;
		case (c)
			8'h5c: esc_dec = 8'h5c;
			8'h22: esc_dec = 8'h22;
			8'h62: esc_dec = 8'h08;
			8'h66: esc_dec = 8'h0c;
			8'h6e: esc_dec = 8'h0a;
			8'h72: esc_dec = 8'h0d;
			8'h74: esc_dec = 8'h09;
			default: esc_ok = 1'b0;
		endcase
	end

	always_comb begin
		st   = cur;
		bad  = 1'b0;
		ob   = 8'h00;
		kind = fjop_pkg::KIND_NONE;
		if (!cur.rejected && !cur.empty_closed) begin
			case (cur.phase)
				fjop_pkg::PH_OPEN: begin
					if (c == 8'h7b) st.phase = fjop_pkg::PH_FIRST;
					else if (!is_ws(c)) bad = 1'b1;
				end
				fjop_pkg::PH_FIRST: begin
					if (c == 8'h7d) st.empty_closed = 1'b1;
					else if (c == 8'h22) st.phase = fjop_pkg::PH_KEY;
					else if (!is_ws(c)) bad = 1'b1;
				end
				fjop_pkg::PH_KEY: begin
					if (c == 8'h22) begin
						kind     = fjop_pkg::KIND_KEY_END;
						st.phase = fjop_pkg::PH_COLON;
					end else if (c == 8'h5c) begin
						st.phase = fjop_pkg::PH_KEY_ESC;
					end else begin
						ob   = c;
						kind = fjop_pkg::KIND_KEY;
					end
				end
				fjop_pkg::PH_VAL: begin
					if (c == 8'h22) begin
						kind     = fjop_pkg::KIND_VAL_END;
						st.phase = fjop_pkg::PH_AFTER_VAL;
					end else if (c == 8'h5c) begin
						st.phase = fjop_pkg::PH_VAL_ESC;
					end else begin
						ob   = c;
						kind = fjop_pkg::KIND_VAL;
					end
				end
				fjop_pkg::PH_KEY_ESC: begin
					if (esc_ok) begin
						ob       = esc_dec;
						kind     = fjop_pkg::KIND_KEY;
						st.phase = fjop_pkg::PH_KEY;
					end else begin
						bad = 1'b1;
					end
				end
				fjop_pkg::PH_VAL_ESC: begin
					if (esc_ok) begin
						ob       = esc_dec;
						kind     = fjop_pkg::KIND_VAL;
						st.phase = fjop_pkg::PH_VAL;
					end else begin
						bad = 1'b1;
					end
				end
				fjop_pkg::PH_COLON: begin
					if (c == 8'h3a) st.phase = fjop_pkg::PH_VAL_OPEN;
					else if (!is_ws(c)) bad = 1'b1;
				end
				fjop_pkg::PH_VAL_OPEN: begin
					if (c == 8'h22) st.phase = fjop_pkg::PH_VAL;
					else if (!is_ws(c)) bad = 1'b1;
				end
				fjop_pkg::PH_AFTER_VAL: begin
					if (c == 8'h7d) st.phase = fjop_pkg::PH_TRAIL;
					else if (c == 8'h2c) st.phase = fjop_pkg::PH_NEXT_KEY;
					else if (!is_ws(c)) bad = 1'b1;
				end
				fjop_pkg::PH_NEXT_KEY: begin
					if (c == 8'h22) st.phase = fjop_pkg::PH_KEY;
					else if (!is_ws(c)) bad = 1'b1;
				end
				fjop_pkg::PH_TRAIL: begin
					if (!is_ws(c)) bad = 1'b1;
				end
				default: bad = 1'b1;
			endcase
			if (bad) begin
				st.rejected = 1'b1;
				kind        = fjop_pkg::KIND_NONE;
				ob          = 8'h00;
			end
		end

		if (st.rejected) verdict = fjop_pkg::VERDICT_REJECTED;
		else if (st.empty_closed) verdict = fjop_pkg::VERDICT_ACCEPTED;
		else if (item.final_byte)
			verdict = (st.phase == fjop_pkg::PH_TRAIL) ? fjop_pkg::VERDICT_ACCEPTED
				: fjop_pkg::VERDICT_REJECTED;
		else verdict = fjop_pkg::VERDICT_UNDECIDED;

		// the last byte of a message returns the parser to its start
		nxt = item.final_byte ? fjop_pkg::STATE_RESET : st;

		result.out_byte    = ob;
		result.kind        = kind;
		result.verdict     = verdict;
		result.message_end = item.final_byte;
	end

endmodule

>>> bench/tb_flat_json_object_parser.sv
// testbench for the flat json object parser: random messages, ready/valid gaps, beat checks
module tb_flat_json_object_parser;

	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD  = 150;
	localparam int HOLD_AT    = 300;
	localparam int RAND_BYTES = 450;

	localparam logic [7:0] CH_LBRACE = "{";
	localparam logic [7:0] CH_RBRACE = "}";
	localparam logic [7:0] CH_COLON  = ":";
	localparam logic [7:0] CH_COMMA  = ",";
	localparam logic [7:0] CH_QUOTE  = "\"";
	localparam logic [7:0] CH_BSLASH = "\\";
	localparam logic [7:0] CH_SPACE  = " ";
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	fjop_pkg::in_beat_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	fjop_pkg::out_beat_t out_data;

	flat_json_object_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// parser state as the bench expects it
	fjop_pkg::phase_t cur_phase = fjop_pkg::PH_OPEN;
	logic             reject_seen = 1'b0;
	logic             empty_done = 1'b0;

	fjop_pkg::in_beat_t  pending_bytes[$];
	fjop_pkg::out_beat_t expected_beats[$];
	logic [7:0]          msg[$];

	int errors = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int msgs_total = 0;
	int msgs_ok = 0;
	int msgs_bad = 0;
	int text_bytes = 0;
	int tx_wait = 0;
	int tx_quiet = 0;
	int rx_wait = 0;
	int rx_quiet = 0;
	int idle_cycles = 0;

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	// one step of the parser: updates the bench state and returns the result beat
	function automatic fjop_pkg::out_beat_t decode_byte(input fjop_pkg::in_beat_t b);
		fjop_pkg::out_beat_t r;
		logic                bad;
		logic [7:0]          c;
		logic                key_side;
		r = '0;
		bad = 1'b0;
		c = b.in_byte;
		if (!reject_seen && !empty_done) begin
			case (cur_phase)
				fjop_pkg::PH_OPEN: begin
					if (c == CH_LBRACE) cur_phase = fjop_pkg::PH_FIRST;
					else if (!is_space(c)) bad = 1'b1;
				end
				fjop_pkg::PH_FIRST: begin
					if (c == CH_RBRACE) empty_done = 1'b1;
					else if (c == CH_QUOTE) cur_phase = fjop_pkg::PH_KEY;
					else if (!is_space(c)) bad = 1'b1;
				end
				fjop_pkg::PH_KEY, fjop_pkg::PH_VAL: begin
					key_side = (cur_phase == fjop_pkg::PH_KEY);
					if (c == CH_QUOTE) begin
						r.kind = key_side ? fjop_pkg::KIND_KEY_END : fjop_pkg::KIND_VAL_END;
						cur_phase = key_side ? fjop_pkg::PH_COLON : fjop_pkg::PH_AFTER_VAL;
					end else if (c == CH_BSLASH) begin
						cur_phase = key_side ? fjop_pkg::PH_KEY_ESC : fjop_pkg::PH_VAL_ESC;
					end else begin
						r.out_byte = c;
						r.kind = key_side ? fjop_pkg::KIND_KEY : fjop_pkg::KIND_VAL;
					end
				end
				fjop_pkg::PH_KEY_ESC, fjop_pkg::PH_VAL_ESC: begin
					key_side = (cur_phase == fjop_pkg::PH_KEY_ESC);
					r.kind = key_side ? fjop_pkg::KIND_KEY : fjop_pkg::KIND_VAL;
					case (c)
						CH_BSLASH: r.out_byte = CH_BSLASH;
						CH_QUOTE:  r.out_byte = CH_QUOTE;
						"b":       r.out_byte = CH_BS;
						"f":       r.out_byte = CH_FF;
						"n":       r.out_byte = CH_LF;
						"r":       r.out_byte = CH_CR;
						"t":       r.out_byte = CH_TAB;
						default:   bad = 1'b1;
					endcase
					if (!bad) cur_phase = key_side ? fjop_pkg::PH_KEY : fjop_pkg::PH_VAL;
				end
				fjop_pkg::PH_COLON: begin
					if (c == CH_COLON) cur_phase = fjop_pkg::PH_VAL_OPEN;
					else if (!is_space(c)) bad = 1'b1;
				end
				fjop_pkg::PH_VAL_OPEN: begin
					if (c == CH_QUOTE) cur_phase = fjop_pkg::PH_VAL;
					else if (!is_space(c)) bad = 1'b1;
				end
				fjop_pkg::PH_AFTER_VAL: begin
					if (c == CH_RBRACE) cur_phase = fjop_pkg::PH_TRAIL;
					else if (c == CH_COMMA) cur_phase = fjop_pkg::PH_NEXT_KEY;
					else if (!is_space(c)) bad = 1'b1;
				end
				fjop_pkg::PH_NEXT_KEY: begin
					if (c == CH_QUOTE) cur_phase = fjop_pkg::PH_KEY;
					else if (!is_space(c)) bad = 1'b1;
				end
				fjop_pkg::PH_TRAIL: begin
					if (!is_space(c)) bad = 1'b1;
				end
				default: bad = 1'b1;
			endcase
			if (bad) begin
				reject_seen = 1'b1;
				r.kind = fjop_pkg::KIND_NONE;
				r.out_byte = '0;
			end
		end

		if (reject_seen) r.verdict = fjop_pkg::VERDICT_REJECTED;
		else if (empty_done) r.verdict = fjop_pkg::VERDICT_ACCEPTED;
		else if (b.final_byte)
			r.verdict = (cur_phase == fjop_pkg::PH_TRAIL) ? fjop_pkg::VERDICT_ACCEPTED
				: fjop_pkg::VERDICT_REJECTED;
		else r.verdict = fjop_pkg::VERDICT_UNDECIDED;
		r.message_end = b.final_byte;

		if (r.kind == fjop_pkg::KIND_KEY || r.kind == fjop_pkg::KIND_VAL) text_bytes++;
		if (b.final_byte) begin
			msgs_total++;
			if (r.verdict == fjop_pkg::VERDICT_ACCEPTED) msgs_ok++;
			else msgs_bad++;
			cur_phase = fjop_pkg::PH_OPEN;
			reject_seen = 1'b0;
			empty_done = 1'b0;
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// queue the bytes in msg as one message, last byte marked
	task automatic flush_msg();
		fjop_pkg::in_beat_t b;
		for (int i = 0; i < msg.size(); i++) begin
			b.in_byte = msg[i];
			b.final_byte = (i == msg.size() - 1);
			pending_bytes.push_back(b);
		end
		msg.delete();
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
		flush_msg();
	endtask

	task automatic add_ws();
		int n;
		n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: msg.push_back(CH_SPACE);
				1: msg.push_back(CH_TAB);
				2: msg.push_back(CH_CR);
				default: msg.push_back(CH_LF);
			endcase
		end
	endtask

	task automatic add_string();
		int         len;
		int         pick;
		logic [7:0] c;
		msg.push_back(CH_QUOTE);
		len = $urandom_range(0, 4);
		repeat (len) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				msg.push_back(CH_BSLASH);
				case ($urandom_range(0, 6))
					0: msg.push_back(CH_BSLASH);
					1: msg.push_back(CH_QUOTE);
					2: msg.push_back("b");
					3: msg.push_back("f");
					4: msg.push_back("n");
					5: msg.push_back("r");
					default: msg.push_back("t");
				endcase
			end else if (pick < 15) begin
				// escape letter left to chance, mostly a bad one
				msg.push_back(CH_BSLASH);
				msg.push_back(8'($urandom_range(0, 255)));
			end else begin
				if (pick < 70) c = 8'($urandom_range(8'h20, 8'h7E));
				else c = 8'($urandom_range(0, 255));
				if (c == CH_QUOTE || c == CH_BSLASH) c = "x";
				msg.push_back(c);
			end
		end
		msg.push_back(CH_QUOTE);
	endtask

	task automatic gen_message();
		int npairs;
		int cut;
		add_ws();
		msg.push_back(CH_LBRACE);
		add_ws();
		if ($urandom_range(0, 9) == 0) begin
			msg.push_back(CH_RBRACE);
			repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom_range(0, 255)));
		end else begin
			npairs = $urandom_range(1, 3);
			for (int p = 0; p < npairs; p++) begin
				if (p > 0) begin
					add_ws();
					msg.push_back(CH_COMMA);
					add_ws();
				end
				add_string();
				add_ws();
				msg.push_back(CH_COLON);
				add_ws();
				add_string();
			end
			add_ws();
			msg.push_back(CH_RBRACE);
			add_ws();
			if ($urandom_range(0, 9) == 0) msg.push_back(8'($urandom_range(0, 255)));
		end
		// a quarter of the messages get broken
		case ($urandom_range(0, 11))
			0: msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
			1: begin
				cut = $urandom_range(1, msg.size());
				while (msg.size() > cut) void'(msg.pop_back());
			end
			2: begin
				msg.delete();
				repeat ($urandom_range(1, 5)) msg.push_back(8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
		flush_msg();
	endtask

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_beats.push_back(decode_byte(in_data));
				bytes_sent++;
			end
			if (!in_valid || in_ready) begin
				if (tx_wait > 0) begin
					tx_wait--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= pending_bytes.pop_front();
					if (tx_quiet > 0) begin
						tx_quiet--;
					end else begin
						tx_wait = pick_gap();
						if ($urandom_range(0, 31) == 0) tx_quiet = $urandom_range(20, 60);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic field_mismatch(input string field, input logic [7:0] want_v,
		input logic [7:0] got_v);
		errors++;
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
	endtask

	// receiver and checker
	always @(posedge clk) begin
		fjop_pkg::out_beat_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_beats.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing expected, expected none, got %p",
						$time, out_data);
				end else begin
					want = expected_beats.pop_front();
					if (out_data.out_byte !== want.out_byte)
						field_mismatch("out_byte", want.out_byte, out_data.out_byte);
					if (out_data.kind !== want.kind)
						field_mismatch("kind", 8'(want.kind), 8'(out_data.kind));
					if (out_data.verdict !== want.verdict)
						field_mismatch("verdict", 8'(want.verdict), 8'(out_data.verdict));
					if (out_data.message_end !== want.message_end)
						field_mismatch("message_end", 8'(want.message_end),
							8'(out_data.message_end));
				end
				if (results_seen == HOLD_AT) begin
					// long back-pressure so the input side backs up
					rx_wait = LONG_HOLD;
				end else if (rx_quiet > 0) begin
					rx_quiet--;
				end else begin
					rx_wait = pick_gap();
					if ($urandom_range(0, 31) == 0) rx_quiet = $urandom_range(20, 60);
				end
			end
			if (rx_wait > 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
				$display("tb_flat_json_object_parser NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int rand_count;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty object accepted despite junk after it
		push_text("{}x");
		// bad escape, then bytes ignored until the end
		push_text("{\"\\q}");
		// every escape, split between key and value
		push_text("{\"\\\\\\\"\\b\":\"\\f\\n\\r\\t\"}");
		// truncated message
		push_text("{");

		// let everything drain before the random part
		while (pending_bytes.size() > 0 || in_valid || expected_beats.size() > 0)
			@(posedge clk);

		rand_count = 0;
		while (rand_count < RAND_BYTES) begin
			rand_count -= pending_bytes.size();
			gen_message();
			rand_count += pending_bytes.size();
		end

		while (pending_bytes.size() > 0 || in_valid || expected_beats.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d bytes in %0d messages: %0d accepted, %0d rejected",
			bytes_sent, msgs_total, msgs_ok, msgs_bad);
		$display("checked %0d result beats, %0d of them decoded text, %0d errors",
			results_seen, text_bytes, errors);
		if (errors == 0) begin
			$display("tb_flat_json_object_parser OK");
		end else begin
			$display("tb_flat_json_object_parser NOT OK");
		end
		$finish;
	end

endmodule
